// ----- src/tspc_pkg.sv -----
// tspc_pkg: shared types, constants and helpers for the text string
// plausibility checker. No dependencies.

package tspc_pkg;

  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 12;
  localparam int POS_W    = 13;
  localparam int LIMIT_W  = 13;
  localparam int VERD_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = 13'd4096;
  localparam int LIMIT_HARD_CAP = 4096;

  // verdict codes
  localparam logic [VERD_W-1:0] VERD_TEXT    = 2'd0;
  localparam logic [VERD_W-1:0] VERD_INVALID = 2'd1;
  localparam logic [VERD_W-1:0] VERD_NOTERM  = 2'd2;
  localparam logic [VERD_W-1:0] VERD_GARBAGE = 2'd3;

  // configuration register indexes
  localparam logic REG_SCAN_LIMIT = 1'b0;

  // ascii codes
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

  typedef logic [CNT_W-1:0] cnt_t;

  // saturating counter increment
  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

endpackage

// ----- src/tspc_if.sv -----
// tspc_if: valid/ready channel interfaces for the byte stream and the verdict.
// Depends on tspc_pkg.

interface tspc_byte_if import tspc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;
  logic              final_available;

  modport source (output valid, data_byte, first_byte, final_available, input ready);
  modport sink (input valid, data_byte, first_byte, final_available, output ready);
endinterface

interface tspc_verdict_if import tspc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VERD_W-1:0] verdict;
  logic [CNT_W-1:0]  text_length;

  modport source (output valid, verdict, text_length, input ready);
  modport sink (input valid, verdict, text_length, output ready);
endinterface

// ----- src/text_string_plausibility_checker.sv -----
// text_string_plausibility_checker: scans candidate strings byte by byte and
// gives one verdict per string. Depends on tspc_pkg and the channel interfaces.
//
// Usage:
//   text_bytes carries one byte a word with first_byte/final_available flags;
//   report carries one verdict word (verdict, text_length) per candidate.
//   A byte with first_byte set starts a new candidate and clears all counts.
//   Scanning stops at a zero byte (verdict text or garbage), at a byte that is
//   not printable ascii/tab/lf/cr (invalid), or when the scan limit is hit or
//   final_available is set without a terminator (no terminator). Bytes after
//   a verdict are dropped until the next first_byte.
// Timing:
//   One byte is taken every cycle unless a held report word stalls it. Each byte
//   updates the running counts and, when it ends the string, loads the report
//   register in the same cycle, so the verdict shows in the cycle after that byte is accepted.
//   The report register is the only buffer: while it holds a word the
//   receiver has not taken, text_bytes.ready stays high only if report.ready
//   is high; a stalled receiver therefore stalls the byte stream.
// Reset (rst, synchronous): scan_limit returns to 4096, scanning stops,
//   all counts clear and the report register empties.
// Config: APB register scan_limit at byte address 0; the user writes it only while idle (not enforced).

module text_string_plausibility_checker
  import tspc_pkg::*;
#(
  parameter int WINDOW_MAX = 4096
) (
  input  logic               clk,
  input  logic               rst,
  tspc_byte_if.sink          text_bytes,
  tspc_verdict_if.source     report,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LIMIT_CAP_I = (WINDOW_MAX < LIMIT_HARD_CAP) ? WINDOW_MAX : LIMIT_HARD_CAP;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(LIMIT_CAP_I);

  // registers
  logic [LIMIT_W-1:0] scan_limit;
  logic               scanning;
  logic [POS_W-1:0]   position;
  cnt_t vowel_count, consonant_count, digit_count, space_count, punct_count;
  cnt_t upper_count, lower_count, consonant_run, longest_run;
  logic               out_valid;
  logic [VERD_W-1:0]  out_verdict;
  logic [CNT_W-1:0]   out_length;

  // apb register port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SCAN_LIMIT);
  assign prdata = (paddr[2] == REG_SCAN_LIMIT) ? {{(32-LIMIT_W){1'b0}}, scan_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= LIMIT_DEFAULT;
    end else if (cfg_wr) begin
      scan_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // effective limit: clamp to 1 .. min(4096, WINDOW_MAX)
  logic [LIMIT_W-1:0] eff_limit;
  always_comb begin
    eff_limit = scan_limit;
    if (eff_limit == '0) eff_limit = LIMIT_W'(1);
    if (eff_limit > LIMIT_CAP) eff_limit = LIMIT_CAP;
  end

  // handshake
  logic accept;
  assign text_bytes.ready = !out_valid || report.ready;
  assign accept = text_bytes.valid && text_bytes.ready;

  // counts as seen by this byte (first_byte clears them)
  logic               first;
  logic               active;
  logic [POS_W-1:0]   cur_pos;
  cnt_t cur_vowel, cur_cons, cur_digit, cur_space, cur_punct;
  cnt_t cur_upper, cur_lower, cur_run, cur_longest;
  assign first  = text_bytes.first_byte;
  assign active = first || scanning;
  assign cur_pos     = first ? '0 : position;
  assign cur_vowel   = first ? '0 : vowel_count;
  assign cur_cons    = first ? '0 : consonant_count;
  assign cur_digit   = first ? '0 : digit_count;
  assign cur_space   = first ? '0 : space_count;
  assign cur_punct   = first ? '0 : punct_count;
  assign cur_upper   = first ? '0 : upper_count;
  assign cur_lower   = first ? '0 : lower_count;
  assign cur_run     = first ? '0 : consonant_run;
  assign cur_longest = first ? '0 : longest_run;

  // byte classification
  logic [BYTE_W-1:0] b, lc;
  logic is_upper, is_lower, is_letter, is_vowel, is_digit, is_space, is_valid, is_nul;
  assign b         = text_bytes.data_byte;
  assign is_upper  = (b >= 8'h41) && (b <= 8'h5A);
  assign is_lower  = (b >= 8'h61) && (b <= 8'h7A);
  assign is_letter = is_upper || is_lower;
  assign lc        = is_upper ? (b | 8'h20) : b;
  assign is_vowel  = is_letter && ((lc == 8'h61) || (lc == 8'h65) || (lc == 8'h69) ||
                                   (lc == 8'h6F) || (lc == 8'h75));
  assign is_digit  = (b >= 8'h30) && (b <= 8'h39);
  assign is_space  = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  assign is_nul    = (b == CH_NUL);
  assign is_valid  = ((b >= CH_SPACE) && (b <= CH_TILDE)) ||
                     (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);

  // garbage heuristics on the counts before the terminator
  logic [CNT_W-1:0] n;
  logic [CNT_W:0]   letters;
  logic [CNT_W+3:0] vowel_x10, letters_x7;
  logic [CNT_W+3:0] letters_w;
  logic             short_ok, ratio_bad, run_bad, case_bad, looks_text;
  assign n          = cur_pos[CNT_W-1:0];
  assign letters    = {1'b0, cur_vowel} + {1'b0, cur_cons};
  assign letters_w  = {3'b000, letters};
  assign vowel_x10  = ({4'b0000, cur_vowel} << 3) + ({4'b0000, cur_vowel} << 1);
  assign letters_x7 = (letters_w << 3) - letters_w;
  assign short_ok   = ((cur_space != '0) && (letters > 13'd4)) ||
                      ((cur_digit != '0) && (letters > 13'd2)) ||
                      ((cur_punct != '0) && (letters > 13'd2));
  assign ratio_bad  = (vowel_x10 < letters_w) || (vowel_x10 > letters_x7);
  assign run_bad    = (n < 12'd8) ? (cur_longest > 12'd5) : (cur_longest > 12'd4);
  assign case_bad   = (n > 12'd20) && (cur_space == '0) && (cur_digit == '0) &&
                      (cur_punct == '0) && ((cur_upper == '0) || (cur_lower == '0));
  always_comb begin
    if (n < 12'd4) begin
      looks_text = 1'b0;
    end else if (short_ok) begin
      looks_text = 1'b1;
    end else if ((letters >= 13'd4) && (ratio_bad || run_bad)) begin
      looks_text = 1'b0;
    end else begin
      looks_text = !case_bad;
    end
  end

  // next values after counting a valid byte
  logic [POS_W-1:0] pos_next;
  cnt_t run_next, longest_next;
  logic             noterm;
  assign pos_next     = (cur_pos == POS_MAX) ? cur_pos : cur_pos + POS_W'(1);
  assign run_next     = (is_letter && !is_vowel) ? sat_inc(cur_run) : '0;
  assign longest_next = (run_next > cur_longest) ? run_next : cur_longest;
  assign noterm       = (pos_next >= eff_limit) || text_bytes.final_available;

  // scan state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning        <= 1'b0;
      position        <= '0;
      vowel_count     <= '0;
      consonant_count <= '0;
      digit_count     <= '0;
      space_count     <= '0;
      punct_count     <= '0;
      upper_count     <= '0;
      lower_count     <= '0;
      consonant_run   <= '0;
      longest_run     <= '0;
    end else if (accept && active) begin
      if (is_nul || !is_valid) begin
        scanning        <= 1'b0;
        position        <= cur_pos;
        vowel_count     <= cur_vowel;
        consonant_count <= cur_cons;
        digit_count     <= cur_digit;
        space_count     <= cur_space;
        punct_count     <= cur_punct;
        upper_count     <= cur_upper;
        lower_count     <= cur_lower;
        consonant_run   <= cur_run;
        longest_run     <= cur_longest;
      end else begin
        scanning        <= !noterm;
        position        <= pos_next;
        vowel_count     <= is_vowel ? sat_inc(cur_vowel) : cur_vowel;
        consonant_count <= (is_letter && !is_vowel) ? sat_inc(cur_cons) : cur_cons;
        digit_count     <= is_digit ? sat_inc(cur_digit) : cur_digit;
        space_count     <= is_space ? sat_inc(cur_space) : cur_space;
        punct_count     <= (!is_letter && !is_digit && !is_space) ?
                           sat_inc(cur_punct) : cur_punct;
        upper_count     <= is_upper ? sat_inc(cur_upper) : cur_upper;
        lower_count     <= is_lower ? sat_inc(cur_lower) : cur_lower;
        consonant_run   <= run_next;
        longest_run     <= longest_next;
      end
    end
  end

  // report register
  logic emit;
  assign emit = accept && active && (is_nul || !is_valid || noterm);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (is_nul) begin
        out_verdict <= looks_text ? VERD_TEXT : VERD_GARBAGE;
        out_length  <= n;
      end else if (!is_valid) begin
        out_verdict <= VERD_INVALID;
        out_length  <= '0;
      end else begin
        out_verdict <= VERD_NOTERM;
        out_length  <= '0;
      end
    end
  end

  assign report.valid       = out_valid;
  assign report.verdict     = out_verdict;
  assign report.text_length = out_length;

  // checks
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_verdict == VERD_INVALID) || (out_verdict == VERD_NOTERM))
    |-> (out_length == '0))
    else $error("nonzero length on invalid or no-terminator verdict");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    scanning |-> (longest_run >= consonant_run))
    else $error("consonant run exceeds longest run");

  a_stop_reports: assert property (@(posedge clk) disable iff (rst)
    $fell(scanning) && !$past(rst) |-> out_valid)
    else $error("scan ended without a verdict");

  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    scanning |-> (position < LIMIT_CAP))
    else $error("position passed the scan limit");

endmodule

// ----- verif/tspc_checker.sv -----
`timescale 1ns / 100ps
// tspc_checker: watches the byte channel, the verdict channel and the register
// port of the plausibility checker, predicts every verdict word and compares.
// Depends on tspc_pkg and the channel interfaces in tspc_if.sv.

module tspc_checker
  import tspc_pkg::*;
#(
  parameter int WINDOW_MAX = 4096
) (
  input  logic        clk,
  input  logic        rst,
  tspc_byte_if        text_bytes,
  tspc_verdict_if     report,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          verdict_tally [4]
);

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic [CNT_W-1:0]  text_length;
  } report_t;

  // verdict words still owed by the block, oldest first
  report_t expected_reports[$];
  report_t seen_word;

  // shadow of the block's register and per-string counts
  logic [LIMIT_W-1:0] limit_reg;
  logic               in_string;
  logic [POS_W-1:0]   byte_pos;
  cnt_t n_vowel, n_cons, n_digit, n_space, n_punct, n_upper, n_lower;
  cnt_t cons_run, longest_run;
  int   n_fail;

  task automatic clear_string_state();
    byte_pos = '0;
    n_vowel = '0; n_cons = '0; n_digit = '0; n_space = '0; n_punct = '0;
    n_upper = '0; n_lower = '0; cons_run = '0; longest_run = '0;
  endtask

  // one accepted byte: update counts, queue a verdict word if the string ends
  task automatic predict_byte(input logic [7:0] b, input logic is_first,
                              input logic is_last);
    report_t word;
    int n, letters, run_cap, lim;
    logic upper, lower, looks_text;
    logic [7:0] lc;
    word.text_length = '0;
    if (is_first) begin
      clear_string_state();
      in_string = 1'b1;
    end
    if (in_string) begin
      if (b == CH_NUL) begin
        // terminated string: garbage heuristics
        n = int'(byte_pos[CNT_W-1:0]);
        letters = int'(n_vowel) + int'(n_cons);
        run_cap = (n < 8) ? 5 : 4;
        if (n < 4)
          looks_text = 1'b0;
        else if (n_space > 0 && letters > 4)
          looks_text = 1'b1;
        else if (n_digit > 0 && letters > 2)
          looks_text = 1'b1;
        else if (n_punct > 0 && letters > 2)
          looks_text = 1'b1;
        else if (letters >= 4 && (int'(n_vowel) * 10 < letters ||
                 int'(n_vowel) * 10 > letters * 7 || int'(longest_run) > run_cap))
          looks_text = 1'b0;
        else if (n > 20 && n_space == 0 && n_digit == 0 && n_punct == 0 &&
                 (n_upper == 0 || n_lower == 0))
          looks_text = 1'b0;
        else
          looks_text = 1'b1;
        word.verdict = looks_text ? VERD_TEXT : VERD_GARBAGE;
        word.text_length = byte_pos[CNT_W-1:0];
        expected_reports.push_back(word);
        in_string = 1'b0;
      end else if (!((b >= CH_SPACE && b <= CH_TILDE) || b inside {CH_TAB, CH_LF, CH_CR})) begin
        word.verdict = VERD_INVALID;
        expected_reports.push_back(word);
        in_string = 1'b0;
      end else begin
        // character class counts, all saturating
        upper = (b >= "A" && b <= "Z");
        lower = (b >= "a" && b <= "z");
        lc = upper ? b + 8'd32 : b;
        if (upper || lower) begin
          if (lc inside {"a", "e", "i", "o", "u"}) begin
            n_vowel += cnt_t'(n_vowel != CNT_MAX);
            cons_run = '0;
          end else begin
            n_cons += cnt_t'(n_cons != CNT_MAX);
            cons_run += cnt_t'(cons_run != CNT_MAX);
            if (cons_run > longest_run) longest_run = cons_run;
          end
          if (upper) n_upper += cnt_t'(n_upper != CNT_MAX);
          else n_lower += cnt_t'(n_lower != CNT_MAX);
        end else if (b >= "0" && b <= "9") begin
          n_digit += cnt_t'(n_digit != CNT_MAX);
          cons_run = '0;
        end else if (b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
          n_space += cnt_t'(n_space != CNT_MAX);
          cons_run = '0;
        end else begin
          n_punct += cnt_t'(n_punct != CNT_MAX);
          cons_run = '0;
        end
        if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;
        // effective limit: zero acts as one, clamp to the hard cap and window
        lim = int'(limit_reg);
        if (lim < 1) lim = 1;
        if (lim > LIMIT_HARD_CAP) lim = LIMIT_HARD_CAP;
        if (lim > WINDOW_MAX) lim = WINDOW_MAX;
        if (int'(byte_pos) >= lim || is_last) begin
          word.verdict = VERD_NOTERM;
          expected_reports.push_back(word);
          in_string = 1'b0;
        end
      end
    end
  endtask

  // monitor: register writes, accepted bytes, accepted verdict words
  always @(posedge clk) begin
    if (rst) begin
      limit_reg = LIMIT_DEFAULT;
      in_string = 1'b0;
      clear_string_state();
      expected_reports.delete();
      n_fail = 0;
      foreach (verdict_tally[i]) verdict_tally[i] = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_SCAN_LIMIT, 2'b00})
        limit_reg = pwdata[LIMIT_W-1:0];
      if (text_bytes.valid && text_bytes.ready)
        predict_byte(text_bytes.data_byte, text_bytes.first_byte,
                     text_bytes.final_available);
      if (report.valid && report.ready) begin
        if (expected_reports.size() == 0) begin
          $error("verdict word with none expected: verdict %0d, text_length %0d",
                 report.verdict, report.text_length);
          n_fail++;
        end else begin
          seen_word = expected_reports.pop_front();
          if (report.verdict !== seen_word.verdict) begin
            $error("verdict mismatch: expected %0d, actual %0d",
                   seen_word.verdict, report.verdict);
            n_fail++;
          end
          if (report.text_length !== seen_word.text_length) begin
            $error("text_length mismatch: expected %0d, actual %0d",
                   seen_word.text_length, report.text_length);
            n_fail++;
          end
          verdict_tally[seen_word.verdict]++;
        end
      end
    end
    pending <= expected_reports.size();
    fail_count <= n_fail;
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// tb: drives byte strings and scan-limit writes into the plausibility checker
// and gives the verdict. Depends on tspc_pkg, the channel interfaces, the block
// and tspc_checker.

module tb;
  import tspc_pkg::*;

  localparam int WINDOW = 4096;
  localparam logic [2:0] ADDR_SCAN_LIMIT = {REG_SCAN_LIMIT, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;  // next register slot, not decoded

  typedef enum int {STY_ANY, STY_WORDS, STY_LOWER, STY_UPPER, STY_MIXED, STY_CONS} style_e;
  typedef enum int {END_NUL, END_LAST, END_BAD, END_OPEN} ending_e;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  int send_idle_pct, recv_idle_pct;
  int bytes_sent;
  int fail_count, pending;
  int verdict_tally [4];

  tspc_byte_if    text_bytes();
  tspc_verdict_if report();

  text_string_plausibility_checker #(.WINDOW_MAX(WINDOW)) uut (
    .clk(clk), .rst(rst), .text_bytes(text_bytes), .report(report),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tspc_checker #(.WINDOW_MAX(WINDOW)) verdict_check (
    .clk(clk), .rst(rst), .text_bytes(text_bytes), .report(report),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending),
    .verdict_tally(verdict_tally)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("timeout: verdict words still owed or stream stuck");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls on the verdict channel
  initial begin
    report.ready <= 1'b0;
    forever begin
      @(posedge clk);
      report.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one byte word, with random gaps before it
  task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      text_bytes.valid <= 1'b0;
      @(posedge clk);
    end
    text_bytes.valid           <= 1'b1;
    text_bytes.data_byte       <= b;
    text_bytes.first_byte      <= is_first;
    text_bytes.final_available <= is_last;
    @(posedge clk);
    while (!text_bytes.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // directed string, either zero-terminated or flagged as the last in memory
  task automatic send_str(input string s, input bit terminated);
    for (int i = 0; i < s.len(); i++)
      send_byte(s.getc(i), i == 0, !terminated && i == s.len() - 1);
    if (terminated) send_byte(CH_NUL, s.len() == 0, 1'b0);
  endtask

  function automatic logic [7:0] pick_char(input style_e sty);
    string vowels = "aeiou";
    string cons = "bcdfghjklmnpqrstvwxyz";
    logic [7:0] c;
    int roll;
    roll = $urandom_range(99);
    c = (roll < 40) ? vowels.getc($urandom_range(4)) : cons.getc($urandom_range(20));
    case (sty)
      STY_ANY: begin
        c = (roll < 4) ? CH_TAB : (roll < 7) ? CH_LF : (roll < 10) ? CH_CR :
            8'($urandom_range(32, 126));
      end
      STY_WORDS: begin
        if (roll < 15) c = CH_SPACE;
        else if (roll < 18) c = 8'($urandom_range(48, 57));
        else if (roll < 21) c = 8'($urandom_range(33, 47));
        else if ($urandom_range(9) == 0) c = c - 8'd32;
      end
      STY_UPPER: c = c - 8'd32;
      STY_MIXED: if ($urandom_range(1)) c = c - 8'd32;
      STY_CONS: begin
        c = cons.getc($urandom_range(20));
        if ($urandom_range(3) == 0) c = c - 8'd32;
      end
      default: ;
    endcase
    return c;
  endfunction

  // candidate of len characters in one style, closed as the ending says
  task automatic send_text(input int len, input style_e sty, input ending_e fin);
    logic [7:0] bad;
    int pick;
    for (int i = 0; i < len; i++)
      send_byte(pick_char(sty), i == 0, fin == END_LAST && i == len - 1);
    if (fin == END_NUL || (fin == END_LAST && len == 0)) begin
      send_byte(CH_NUL, len == 0, 1'($urandom_range(1)));
    end else if (fin == END_BAD) begin
      pick = $urandom_range(3);
      bad = (pick == 0) ? 8'($urandom_range(1, 8)) : (pick == 1) ? 8'($urandom_range(11, 12)) :
            (pick == 2) ? 8'($urandom_range(14, 31)) : 8'($urandom_range(127, 255));
      send_byte(bad, len == 0, 1'($urandom_range(1)));
    end
  endtask

  // mostly well-formed candidates, some noise bursts and stray bytes
  task automatic send_candidate();
    int pick, len;
    ending_e fin;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6))
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      pick = $urandom_range(99);
      len = (pick < 70) ? $urandom_range(0, 12) :
            (pick < 95) ? $urandom_range(13, 40) : $urandom_range(41, 120);
      pick = $urandom_range(99);
      fin = (pick < 65) ? END_NUL : (pick < 80) ? END_LAST : (pick < 90) ? END_BAD : END_OPEN;
      send_text(len, style_e'($urandom_range(int'(STY_CONS))), fin);
      // stray byte after the verdict, or continuing an open string
      if ($urandom_range(9) == 0)
        send_byte(8'($urandom_range(1, 255)), 1'b0, 1'($urandom_range(1)));
    end
  endtask

  // stop sending, wait for every owed verdict word, let the block settle
  task automatic drain();
    text_bytes.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stimulus
  initial begin
    int target;
    logic [31:0] limits [6];
    int budget [6];
    limits = '{32'h0000_0001, 32'hFFFF_E001, 32'h0000_0000,
               32'h0000_1000, 32'd25, 32'h0000_1FFF};
    budget = '{150, 400, 400, 400, 400, 400};

    rst = 1'b1;
    text_bytes.valid <= 1'b0;
    text_bytes.data_byte <= '0;
    text_bytes.first_byte <= 1'b0;
    text_bytes.final_available <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    send_idle_pct = 17;
    recv_idle_pct = 56;
    bytes_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: byte outside a string, empty string flagged last, bad bytes,
    // missing terminator, short text, white space only, consonant pile
    send_byte("A", 1'b0, 1'b0);
    send_byte(CH_NUL, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b1, 1'b0);
    send_byte(8'h1F, 1'b1, 1'b0);
    send_str("ab", 1'b0);
    send_str("Hi 7~", 1'b1);
    send_str("\t\n\015 ", 1'b1);
    send_str("bcdfgh", 1'b1);

    // random segments, each under its own scan limit and idling mix
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      send_idle_pct = (seg < 2) ? 17 : (seg < 4) ? 56 : 0;
      recv_idle_pct = (seg < 2) ? 56 : (seg < 4) ? 17 : 0;
      reg_write(ADDR_SCAN_LIMIT, limits[seg]);
      if (seg == 3) begin
        // unmapped slot must not disturb the limit
        reg_write(ADDR_UNMAPPED, $urandom);
      end
      target = bytes_sent + budget[seg];
      while (bytes_sent < target) send_candidate();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("run: %0d bytes, scan limits 1, 4096 and out-of-range values, three stall mixes",
             bytes_sent);
    $display("verdicts: %0d text, %0d invalid, %0d no terminator, %0d garbage",
             verdict_tally[VERD_TEXT], verdict_tally[VERD_INVALID],
             verdict_tally[VERD_NOTERM], verdict_tally[VERD_GARBAGE]);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
